// ===== hdl/bspc_pkg.sv =====
`default_nettype none

package bspc_pkg;

    // sequence field width and length register width
    localparam int SEQ_W   = 32;
    localparam int LEN_W   = 6;
    localparam int MAX_LEN = 32;

    // pipeline depth from input register to output register
    localparam int PIPE_DEPTH = 6;

    // rotation candidates: four variants, each taken at every rotation amount
    localparam int NUM_VAR  = 4;
    localparam int NUM_CAND = NUM_VAR * SEQ_W;

    typedef logic [SEQ_W-1:0] seq_t;
    typedef logic [LEN_W-1:0] len_t;

    localparam len_t LEN_RESET = len_t'(32);
    localparam len_t LEN_MIN   = len_t'(1);
    localparam len_t LEN_LIMIT = len_t'((MAX_LEN < SEQ_W) ? MAX_LEN : SEQ_W);

    function automatic seq_t bit_reverse(input seq_t v);
        seq_t r;
        for (int i = 0; i < SEQ_W; i++)
        begin
            r[i] = v[SEQ_W-1-i];
        end
        return r;
    endfunction

    function automatic seq_t min2(input seq_t x, input seq_t y);
        return (x < y) ? x : y;
    endfunction

    function automatic seq_t min4(input seq_t w, input seq_t x, input seq_t y, input seq_t z);
        return min2(min2(w, x), min2(y, z));
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bspc_canon.sv =====
`default_nettype none

module bspc_canon
    import bspc_pkg::*;
(
    input  wire logic clk,
    input  wire logic en,
    input  wire len_t len_in,
    input  wire seq_t seq_in,
    output seq_t      canon_out
);

    // stage 1: captured input
    seq_t seq1_reg;
    len_t len1_reg;

    // stage 2: four variants in right-aligned and left-aligned form
    seq_t val2_reg [NUM_VAR];
    seq_t pal2_reg [NUM_VAR];
    seq_t mask2_reg;
    len_t len2_reg;

    // stages 3 to 5: minimum tree, four to one per stage
    seq_t min3_reg [NUM_CAND/4];
    seq_t min4_reg [NUM_CAND/16];
    seq_t min5_reg [NUM_CAND/64];

    seq_t val2_next [NUM_VAR];
    seq_t pal2_next [NUM_VAR];
    seq_t mask2_next;
    seq_t cand      [NUM_CAND];

    logic [$clog2(SEQ_W)-1:0] sh1;
    seq_t                     s1;
    seq_t                     p1;
    seq_t                     r1;
    seq_t                     top_mask1;

    // masking, alignment, reversal and complement
    always_comb
    begin
        sh1        = $clog2(SEQ_W)'(len_t'(SEQ_W) - len1_reg);
        mask2_next = {SEQ_W{1'b1}} >> sh1;
        top_mask1  = {SEQ_W{1'b1}} << sh1;
        s1         = seq1_reg & mask2_next;
        p1         = s1 << sh1;
        r1         = bit_reverse(s1);
        val2_next[0] = s1;
        pal2_next[0] = p1;
        val2_next[1] = r1 >> sh1;
        pal2_next[1] = r1;
        val2_next[2] = ~s1 & mask2_next;
        pal2_next[2] = ~p1 & top_mask1;
        val2_next[3] = ~(r1 >> sh1) & mask2_next;
        pal2_next[3] = ~r1 & top_mask1;
    end

    // every rotation is a fixed select of the two aligned copies
    always_comb
    begin
        for (int j = 0; j < NUM_VAR; j++)
        begin
            for (int k = 0; k < SEQ_W; k++)
            begin
                if (len_t'(k) < len2_reg)
                begin
                    cand[j*SEQ_W+k] = ((val2_reg[j] << k) | (pal2_reg[j] >> (SEQ_W - k)))
                                      & mask2_reg;
                end
                else
                begin
                    cand[j*SEQ_W+k] = val2_reg[j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seq1_reg  <= seq_in;
            len1_reg  <= len_in;
            mask2_reg <= mask2_next;
            len2_reg  <= len1_reg;
            for (int j = 0; j < NUM_VAR; j++)
            begin
                val2_reg[j] <= val2_next[j];
                pal2_reg[j] <= pal2_next[j];
            end
            for (int i = 0; i < NUM_CAND/4; i++)
            begin
                min3_reg[i] <= min4(cand[4*i], cand[4*i+1], cand[4*i+2], cand[4*i+3]);
            end
            for (int i = 0; i < NUM_CAND/16; i++)
            begin
                min4_reg[i] <= min4(min3_reg[4*i], min3_reg[4*i+1],
                                    min3_reg[4*i+2], min3_reg[4*i+3]);
            end
            for (int i = 0; i < NUM_CAND/64; i++)
            begin
                min5_reg[i] <= min4(min4_reg[4*i], min4_reg[4*i+1],
                                    min4_reg[4*i+2], min4_reg[4*i+3]);
            end
        end
    end

    assign canon_out = min2(min5_reg[0], min5_reg[1]);

endmodule

`default_nettype wire

// ===== hdl/binary_sequence_pair_canonicalizer.sv =====
// latency: six register stages from the input capture to the output register that drives m_tdata
// throughput: one pair per cycle; a stalled output freezes the whole pipeline in place
// the rotation minimum runs through a four-way registered tree, two compare levels a stage
// reset (rst_n, asynchronous, active low): pipeline emptied, seq_length back to 32
// datapath registers are not reset; only valid bits and the length register are
`default_nettype none

module binary_sequence_pair_canonicalizer
    import bspc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // configuration: symbols used per sequence
    input  wire logic                 seq_length_we,
    input  wire len_t                 seq_length_data,

    // input stream, tdata: seq_a [31:0], seq_b [63:32]
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [2*SEQ_W-1:0]   s_tdata,

    // output stream, tdata: canon_first [31:0], canon_second [63:32]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [2*SEQ_W-1:0]        m_tdata
);

    len_t                  seq_length_reg;
    len_t                  eff_len;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic                  advance;

    seq_t canon_a;
    seq_t canon_b;
    seq_t first_reg;
    seq_t second_reg;
    seq_t first_next;
    seq_t second_next;

    // length register, to be written only while the pipeline is empty; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_length_reg <= LEN_RESET;
        end
        else if (seq_length_we)
        begin
            seq_length_reg <= seq_length_data;
        end
    end

    // zero length behaves as one symbol, long lengths saturate at the field width
    always_comb
    begin
        priority if (seq_length_reg == '0)
        begin
            eff_len = LEN_MIN;
        end
        else if (seq_length_reg > LEN_LIMIT)
        begin
            eff_len = LEN_LIMIT;
        end
        else
        begin
            eff_len = seq_length_reg;
        end
    end

    // the whole pipeline moves together unless the output holds a result not yet taken
    assign advance  = !valid_reg[PIPE_DEPTH-1] || m_tready;
    assign s_tready = advance;

    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    // one canonicaliser per sequence, stages one to five
    bspc_canon u_canon_a
    (
        .clk       (clk),
        .en        (advance),
        .len_in    (eff_len),
        .seq_in    (s_tdata[SEQ_W-1:0]),
        .canon_out (canon_a)
    );

    bspc_canon u_canon_b
    (
        .clk       (clk),
        .en        (advance),
        .len_in    (eff_len),
        .seq_in    (s_tdata[2*SEQ_W-1:SEQ_W]),
        .canon_out (canon_b)
    );

    // final ordering, the smaller canonical form goes first
    always_comb
    begin
        if (canon_a < canon_b)
        begin
            first_next  = canon_a;
            second_next = canon_b;
        end
        else
        begin
            first_next  = canon_b;
            second_next = canon_a;
        end
    end

    // output register, stage six
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    assign m_tvalid = valid_reg[PIPE_DEPTH-1];
    assign m_tdata  = {second_reg, first_reg};

endmodule

`default_nettype wire

// ===== hdl/bspc_checker.sv =====
`default_nettype none

module bspc_checker
    import bspc_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [2*SEQ_W-1:0] m_tdata
);

    // a result not taken stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output transaction changed while stalled");

    // the pair leaves ordered
    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[SEQ_W-1:0] <= m_tdata[2*SEQ_W-1:SEQ_W])
        else $error("canonical pair out of order");

    // complement choice always leaves the top field bit clear
    a_top_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[SEQ_W-1] && !m_tdata[2*SEQ_W-1])
        else $error("canonical form has top bit set");

    // input is only held off by a stalled output
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_tvalid && !m_tready) |-> s_tready)
        else $error("input stalled with free output");

endmodule

bind binary_sequence_pair_canonicalizer bspc_checker u_bspc_checker (.*);

`default_nettype wire
